>>> src/bde_pkg.sv
`timescale 1ns / 1ps
package bde_pkg;

	localparam int VALUE_W   = 17;
	localparam int WEIGHT_W  = 17;
	localparam int WIDX_W    = 5;
	localparam int DEG_W     = 5;
	localparam int DENS_W    = 22;
	localparam int APB_AW    = 2;
	localparam int APB_DW    = 32;

	localparam logic [DENS_W-1:0] DENSITY_MAX = 22'd2097152;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	// register map (byte addresses)
	localparam logic [APB_AW-1:0] ADDR_DEGREE = 2'd0;

	typedef struct packed {
		logic wr_en;    // store one weight
		logic load_en;  // copy weights into the cell row, latch point
		logic step_en;  // advance the row one de Casteljau level
		logic scale_en; // scale by m+1, saturate, fill output register
	} bde_cmd_t;

endpackage

>>> src/bde_in_if.sv
`timescale 1ns / 1ps
interface bde_in_if
	import bde_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [WIDX_W-1:0]  weight_index;
	logic [VALUE_W-1:0] value;
	logic               last_in;

	modport source (output valid, kind, weight_index, value, last_in, input ready);
	modport sink   (input valid, kind, weight_index, value, last_in, output ready);
endinterface

>>> src/bde_out_if.sv
`timescale 1ns / 1ps
interface bde_out_if
	import bde_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [DENS_W-1:0] density;
	logic              last_out;

	modport source (output valid, density, last_out, input ready);
	modport sink   (input valid, density, last_out, output ready);
endinterface

>>> src/bde_lerp_cell.sv
`timescale 1ns / 1ps
module bde_lerp_cell
	import bde_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int U_W       = 17
) (
	input  logic [WEIGHT_W-1:0] a,
	input  logic [WEIGHT_W-1:0] b,
	input  logic [U_W-1:0]      u,
	output logic [WEIGHT_W-1:0] r
);

	localparam int D_W = WEIGHT_W + 1;
	localparam int P_W = D_W + U_W + 1;
	localparam logic signed [P_W-1:0] HALF = P_W'(64'd1 << (FRAC_BITS - 1));

	logic signed [D_W-1:0] diff;
	logic signed [P_W-1:0] diff_ext;
	logic signed [P_W-1:0] u_ext;
	logic signed [P_W-1:0] prod;
	logic signed [P_W-1:0] shifted;
	logic        [D_W-1:0] sum;

	// r = a + floor(((b - a) * u + half) / 2^FRAC_BITS)
	assign diff     = $signed({1'b0, b}) - $signed({1'b0, a});
	assign diff_ext = P_W'(diff);
	assign u_ext    = $signed(P_W'({1'b0, u}));
	assign prod     = diff_ext * u_ext;
	assign shifted  = (prod + HALF) >>> FRAC_BITS;
	// result stays between a and b, so the top bit drops
	assign sum      = D_W'(shifted) + D_W'({1'b0, a});
	assign r        = sum[WEIGHT_W-1:0];

endmodule

>>> src/bde_ctrl.sv
`timescale 1ns / 1ps
module bde_ctrl
	import bde_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic [DEG_W-1:0] m_sat,
	output bde_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_SCALE
	} state_t;

	state_t           state_q;
	logic [DEG_W-1:0] cnt_q;
	logic [DEG_W-1:0] m_q;
	logic             out_valid_q;
	logic             in_beat;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.wr_en    = in_beat && (in_kind == KIND_WRITE);
		cmd.load_en  = in_beat && (in_kind == KIND_EVAL);
		cmd.step_en  = (state_q == ST_STEP);
		cmd.scale_en = (state_q == ST_SCALE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			m_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// fill on scale, drop once the beat is taken
			if (cmd.scale_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat && (in_kind == KIND_EVAL)) begin
						m_q   <= m_sat;
						cnt_q <= '0;
						state_q <= (m_sat == '0) ? ST_SCALE : ST_STEP;
					end
				end
				ST_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == m_q - 1'b1) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (cnt_q < m_q))
		else $error("step count ran past degree");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.load_en) && !(cmd.step_en && cmd.scale_en))
		else $error("conflicting datapath commands");
	a_scale_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale_en |=> out_valid_q)
		else $error("scaled result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.scale_en)
		else $error("pending result overwritten");
`endif

endmodule

>>> src/bde_datapath.sv
`timescale 1ns / 1ps
module bde_datapath
	import bde_pkg::*;
#(
	parameter int MAX_WEIGHTS = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                clk,
	input  bde_cmd_t            cmd,
	input  logic [WIDX_W-1:0]   weight_index,
	input  logic [VALUE_W-1:0]  value,
	input  logic                last_in,
	input  logic [DEG_W-1:0]    m_sat,
	output logic [DENS_W-1:0]   density,
	output logic                last_out
);

	localparam int IDX_W = $clog2(MAX_WEIGHTS);
	localparam int EW    = (IDX_W > WIDX_W) ? IDX_W : WIDX_W;
	localparam int U_W   = (VALUE_W > FRAC_BITS + 1) ? VALUE_W : FRAC_BITS + 1;
	localparam int SP_W  = WEIGHT_W + DEG_W + 1;
	localparam logic [EW:0]    N_ENTRIES = (EW + 1)'(MAX_WEIGHTS);
	localparam logic [U_W-1:0] U_ONE     = U_W'(64'd1 << FRAC_BITS);

	logic [WEIGHT_W-1:0] weights_q [MAX_WEIGHTS];
	logic [WEIGHT_W-1:0] row_q     [MAX_WEIGHTS];
	logic [WEIGHT_W-1:0] cell_r    [MAX_WEIGHTS-1];
	logic [U_W-1:0]      u_q;
	logic [DEG_W-1:0]    m_q;
	logic                last_q;
	logic [DENS_W-1:0]   density_q;
	logic                last_out_q;

	logic [EW-1:0]       widx_ext;
	logic [U_W-1:0]      val_ext;
	logic [DEG_W:0]      m_plus;
	logic [SP_W-1:0]     scaled;

	assign widx_ext = EW'(weight_index);
	assign val_ext  = U_W'(value);

	// drop writes beyond the table
	always_ff @(posedge clk) begin
		if (cmd.wr_en && ({1'b0, widx_ext} < N_ENTRIES)) begin
			weights_q[widx_ext[IDX_W-1:0]] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			u_q    <= (val_ext > U_ONE) ? U_ONE : val_ext;
			m_q    <= m_sat;
			last_q <= last_in;
		end
	end

	for (genvar j = 0; j < MAX_WEIGHTS - 1; j++) begin : g_cell
		bde_lerp_cell #(
			.FRAC_BITS (FRAC_BITS),
			.U_W       (U_W)
		) u_cell (
			.a (row_q[j]),
			.b (row_q[j+1]),
			.u (u_q),
			.r (cell_r[j])
		);

		always_ff @(posedge clk) begin
			if (cmd.load_en) begin
				row_q[j] <= weights_q[j];
			end else if (cmd.step_en) begin
				row_q[j] <= cell_r[j];
			end
		end
	end

	// last entry has no right neighbor: load only, hold during steps
	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			row_q[MAX_WEIGHTS-1] <= weights_q[MAX_WEIGHTS-1];
		end
	end

	assign m_plus = (DEG_W + 1)'(m_q) + 1'b1;
	assign scaled = SP_W'(row_q[0]) * SP_W'(m_plus);

	always_ff @(posedge clk) begin
		if (cmd.scale_en) begin
			density_q  <= (scaled > SP_W'(DENSITY_MAX)) ? DENSITY_MAX : scaled[DENS_W-1:0];
			last_out_q <= last_q;
		end
	end

	assign density  = density_q;
	assign last_out = last_out_q;

endmodule

>>> src/bernstein_density_eval.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat payload                               Accepted when
// --------  ---  -----------------------------------------  -------------------------------
// in_ch     in   kind, weight_index, value, last_in         in_ch.valid && in_ch.ready
// out_ch    out  density, last_out                          out_ch.valid && out_ch.ready
// apb       in   degree at byte address 0                   psel && penable && pwrite
//
// A write beat stores the weight at the accepting edge.
// An evaluate beat loads the lerp cell row from the weight table, then runs m
// row steps (m = degree, at most 31), then scales by m+1.
// Reset clears the controller and the degree register; weights are undefined
// until written.
// The finished density waits in an output register; in_ch takes the next beat
// meanwhile, and the next evaluation holds in its scale step until out_ch drains.
module bernstein_density_eval
	import bde_pkg::*;
#(
	parameter int MAX_WEIGHTS = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	bde_in_if.sink            in_ch,
	bde_out_if.source         out_ch
);

	// largest usable degree given the table depth
	localparam int MAX_DEG = (MAX_WEIGHTS - 1 > 31) ? 31 : MAX_WEIGHTS - 1;

	logic [DEG_W-1:0] degree_q;
	logic [DEG_W-1:0] m_sat;
	logic             cfg_wr;
	bde_cmd_t         cmd;

	// register file: one register, degree
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_DEGREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (cfg_wr) begin
			degree_q <= pwdata[DEG_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_DEGREE) ? APB_DW'(degree_q) : '0;

	// clamp degree to the weight table
	assign m_sat = (degree_q > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : degree_q;

	bde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_kind   (in_ch.kind),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.m_sat     (m_sat),
		.cmd       (cmd)
	);

	bde_datapath #(
		.MAX_WEIGHTS (MAX_WEIGHTS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.weight_index (in_ch.weight_index),
		.value        (in_ch.value),
		.last_in      (in_ch.last_in),
		.m_sat        (m_sat),
		.density      (out_ch.density),
		.last_out     (out_ch.last_out)
	);

endmodule

>>> dv/bernstein_density_eval_tb.sv
`timescale 1ns / 1ps
module bernstein_density_eval_tb;
	import bde_pkg::*;

	localparam int  MAX_W      = 32;
	localparam int  FRAC       = 16;
	localparam int  UNIT       = 1 << FRAC;          // u = 1.0 in Q1.16
	localparam int  HALF       = 1 << (FRAC - 1);    // rounding offset of one lerp step
	localparam int  SETTLE     = 40;                 // margin for the longest evaluation, m = 31
	localparam int  CYCLE_CAP  = 600000;
	localparam int  PHASES     = 8;
	localparam int  PHASE_BEATS = 210;

	typedef struct {
		logic [DENS_W-1:0] density;
		logic              last_out;
	} density_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bde_in_if  in_bus ();
	bde_out_if out_bus ();

	bernstein_density_eval #(
		.MAX_WEIGHTS(MAX_W),
		.FRAC_BITS  (FRAC)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	// Mirror of the block's state: weight table and degree register.
	logic [WEIGHT_W-1:0] weight_mirror [MAX_W];
	logic [DEG_W-1:0]    degree_mirror;

	// Densities still owed by the block, oldest first.
	density_result_t pending_densities [$];

	int error_count;
	int cycle_count;

	// Sender pacing: bursts of random length separated by random gaps.
	bit tx_throttle;
	int burst_left;

	// Receiver pacing: alternating runs of ready and stall.
	bit rx_throttle;
	bit rx_stall;
	int rx_run;

	always #6 clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: flip between ready and stalled runs; runs of plain ready when
	// throttling is off.
	always @(negedge clk) begin
		if (rx_run == 0) begin
			if (rx_throttle) begin
				rx_stall = !rx_stall;
				rx_run   = rx_stall ? $urandom_range(1, 12) : $urandom_range(0, 16);
			end else begin
				rx_stall = 1'b0;
				rx_run   = 8;
			end
		end else begin
			rx_run--;
		end
		out_bus.ready = !rx_stall;
	end

	// Density predictor: de Casteljau over weights 0..m with round-half-up lerp
	// steps (floor of a signed value, so an arithmetic shift), then scale by m+1
	// and clamp to the output range. Points above one count as one.
	function automatic logic [DENS_W-1:0] predict_density(input logic [VALUE_W-1:0] point);
		longint row [MAX_W];
		longint u;
		longint span;
		longint dens;
		int     m;
		int     j;
		int     k;
		m = (degree_mirror > MAX_W - 1) ? MAX_W - 1 : degree_mirror;
		u = point;
		if (u > UNIT)
			u = UNIT;
		for (j = 0; j <= m; j++)
			row[j] = weight_mirror[j];
		for (k = 1; k <= m; k++) begin
			for (j = 0; j + k <= m; j++) begin
				span   = (row[j + 1] - row[j]) * u + HALF;
				row[j] = row[j] + (span >>> FRAC);
			end
		end
		dens = row[0] * (m + 1);
		if (dens < 0)
			dens = 0;
		if (dens > longint'(DENSITY_MAX))
			dens = DENSITY_MAX;
		return DENS_W'(dens);
	endfunction

	// Mostly in-range Q0.16 / Q1.16 values, with the ends and values above one
	// mixed in so that bit 16 toggles.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return VALUE_W'(UNIT);
			2:       return VALUE_W'($urandom_range(UNIT + 1, (1 << VALUE_W) - 1));
			default: return VALUE_W'($urandom_range(0, UNIT));
		endcase
	endfunction

	// Result checker: compare every accepted beat with the oldest prediction.
	always @(posedge clk) begin
		density_result_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (pending_densities.size() == 0) begin
				$error("unexpected result beat: density %0d, last_out %0b",
					out_bus.density, out_bus.last_out);
				error_count++;
			end else begin
				want = pending_densities.pop_front();
				if (out_bus.density !== want.density) begin
					$error("density mismatch: expected %0d, got %0d",
						want.density, out_bus.density);
					error_count++;
				end
				if (out_bus.last_out !== want.last_out) begin
					$error("last_out mismatch: expected %0b, got %0b",
						want.last_out, out_bus.last_out);
					error_count++;
				end
			end
		end
	end

	// Send one beat. Called and returning at a falling edge. Valid drops only
	// when a gap opens, so back-to-back beats keep it high.
	task automatic send_beat(input logic kind, input logic [WIDX_W-1:0] idx,
			input logic [VALUE_W-1:0] val, input logic last);
		int gap;
		if (tx_throttle && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			in_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_bus.valid        = 1'b1;
		in_bus.kind         = kind;
		in_bus.weight_index = idx;
		in_bus.value        = val;
		in_bus.last_in      = last;
		forever begin
			@(posedge clk);
			if (in_bus.ready)
				break;
		end
		// Beat accepted: update the mirror or log the density it owes.
		if (kind == KIND_WRITE)
			weight_mirror[idx] = val;
		else
			pending_densities.push_back('{predict_density(val), last});
		@(negedge clk);
	endtask

	// Hold off the sender until every owed density has come back, then let
	// trailing write beats retire.
	task automatic drain();
		in_bus.valid = 1'b0;
		while (pending_densities.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = addr;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Reprogram the degree on an idle block and read it back.
	task automatic set_degree(input logic [DEG_W-1:0] m);
		logic [APB_DW-1:0] rd;
		drain();
		apb_access(1'b1, ADDR_DEGREE, APB_DW'(m), rd);
		degree_mirror = m;
		apb_access(1'b0, ADDR_DEGREE, '0, rd);
		if (rd !== APB_DW'(m)) begin
			$error("degree readback mismatch: expected %0d, got %0d", m, rd);
			error_count++;
		end
	endtask

	// Directed corners: weight extremes, points at zero, one and above one,
	// degrees 0, 1 and 3, last flag both ways.
	task automatic test_directed();
		tx_throttle = 1'b0;
		rx_throttle = 1'b0;
		send_beat(KIND_WRITE, 5'd0,  17'd65536,  1'b0);
		send_beat(KIND_WRITE, 5'd1,  17'd131071, 1'b0);
		send_beat(KIND_WRITE, 5'd2,  17'd0,      1'b0);
		send_beat(KIND_WRITE, 5'd3,  17'd1,      1'b0);
		send_beat(KIND_WRITE, 5'd31, 17'd131071, 1'b1);
		// degree 0 out of reset: density is just weight 0
		send_beat(KIND_EVAL, 5'd0,  17'd0,      1'b0);
		send_beat(KIND_EVAL, 5'd31, 17'd65536,  1'b1);
		send_beat(KIND_EVAL, 5'd0,  17'd131071, 1'b0);
		set_degree(5'd1);
		send_beat(KIND_EVAL, 5'd0, 17'd0,     1'b0);
		send_beat(KIND_EVAL, 5'd0, 17'd32768, 1'b0);
		send_beat(KIND_EVAL, 5'd0, 17'd65536, 1'b0);
		send_beat(KIND_EVAL, 5'd0, 17'd65537, 1'b1);
		set_degree(5'd3);
		rx_throttle = 1'b1;
		send_beat(KIND_EVAL, 5'd0, 17'd1,      1'b0);
		send_beat(KIND_EVAL, 5'd0, 17'd32768,  1'b0);
		send_beat(KIND_EVAL, 5'd0, 17'd100000, 1'b1);
	endtask

	// Fill the whole table so that any degree reads written weights only.
	task automatic test_fill_weights();
		int i;
		tx_throttle = 1'b1;
		for (i = 0; i < MAX_W; i++)
			send_beat(KIND_WRITE, WIDX_W'(i), pick_value(), 1'($urandom_range(0, 1)));
	endtask

	// Mixed writes and evaluations across degree settings, extremes first.
	// The first phase runs with no throttling on either side.
	task automatic test_random_traffic();
		logic [DEG_W-1:0] m;
		int               p;
		int               n;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       m = 5'd31;
				1:       m = 5'd0;
				2:       m = 5'd1;
				3:       m = 5'd2;
				default: m = DEG_W'($urandom_range(0, MAX_W - 1));
			endcase
			set_degree(m);
			tx_throttle = (p != 0) && ($urandom_range(0, 3) != 0);
			rx_throttle = (p != 0) && ($urandom_range(0, 3) != 0);
			burst_left  = 0;
			for (n = 0; n < PHASE_BEATS; n++) begin
				// hold the sender once per phase until the block has emptied
				if (n == PHASE_BEATS / 2)
					drain();
				if ($urandom_range(0, 3) == 0)
					send_beat(KIND_WRITE, WIDX_W'($urandom_range(0, MAX_W - 1)),
						pick_value(), 1'($urandom_range(0, 1)));
				else
					send_beat(KIND_EVAL, WIDX_W'($urandom_range(0, MAX_W - 1)),
						pick_value(), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		in_bus.valid        = 1'b0;
		in_bus.kind         = KIND_WRITE;
		in_bus.weight_index = '0;
		in_bus.value        = '0;
		in_bus.last_in      = 1'b0;
		out_bus.ready       = 1'b0;
		degree_mirror       = '0;
		error_count         = 0;
		cycle_count         = 0;
		tx_throttle         = 1'b0;
		burst_left          = 0;
		rx_throttle         = 1'b0;
		rx_stall            = 1'b0;
		rx_run              = 0;
		for (int i = 0; i < MAX_W; i++)
			weight_mirror[i] = '0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_fill_weights();
		test_random_traffic();
		drain();

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
